### rtl/spim_pkg.sv
package spim_pkg;

    localparam int unsigned BITS_PER_WORD = 8;
    localparam logic [2:0]  LAST_BIT      = 3'(BITS_PER_WORD - 1);

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_SPI_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LSB_FIRST    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_LENGTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_MOSI     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_MISO     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_SELECT   = 3'd6;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic       command;
        logic       miso_level;
        logic [7:0] tx_byte;
    } cmd_t;

    typedef struct packed {
        logic       sclk;
        logic       mosi;
        logic       mosi_enable;
        logic       select_n;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_last;
        logic [7:0] byte_position;
        logic       done_res;
        logic       busy_res;
    } rsp_t;

    typedef struct packed {
        logic [1:0] spi_mode;
        logic       lsb_first;
        logic [7:0] read_length;
        logic [7:0] write_length;
        logic       use_mosi;
        logic       use_miso;
        logic       use_select;
    } cfg_t;

    typedef struct packed {
        logic       active;
        logic [7:0] byte_count;
        logic [2:0] bit_count;
        logic       half_phase;
        logic [7:0] tx_shift;
        logic [7:0] rx_shift;
        logic       clock_level;
        logic       data_level;
        logic       select_level;
    } bus_state_t;

endpackage

### rtl/spim_step.sv
module spim_step (
    input  spim_pkg::cfg_t       cfg,
    input  spim_pkg::bus_state_t cur,
    input  spim_pkg::cmd_t       cmd,
    output spim_pkg::bus_state_t nxt,
    output spim_pkg::rsp_t       rsp
);

    logic       cpol;
    logic       cpha;
    logic [7:0] total;
    logic [2:0] pos;
    logic       sample;
    logic       byte_start;

    assign cpol       = cfg.spi_mode[1];
    assign cpha       = cfg.spi_mode[0];
    assign total      = (cfg.read_length > cfg.write_length) ? cfg.read_length
                                                              : cfg.write_length;
    assign byte_start = !cur.half_phase && (cur.bit_count == 3'd0);
    assign pos        = cfg.lsb_first ? cur.bit_count : (spim_pkg::LAST_BIT - cur.bit_count);

    always_comb
    begin
        nxt                = cur;
        sample             = 1'b0;
        rsp.rx_byte        = 8'd0;
        rsp.rx_valid       = 1'b0;
        rsp.rx_last        = 1'b0;
        rsp.done_res       = 1'b0;
        rsp.byte_position  = cur.byte_count;

        if (cmd.command == spim_pkg::CMD_START)
        begin
            nxt.active      = 1'b1;
            nxt.byte_count  = 8'd0;
            nxt.bit_count   = 3'd0;
            nxt.half_phase  = 1'b0;
            nxt.rx_shift    = 8'd0;
            nxt.tx_shift    = 8'd0;
            nxt.clock_level = cpol;
            if (cfg.use_select)
            begin
                nxt.select_level = 1'b0;
            end
            rsp.byte_position = 8'd0;
        end
        else if (cur.active)
        begin
            if (byte_start && (cur.byte_count >= total))
            begin
                // closing tick
                if (cfg.use_select)
                begin
                    nxt.select_level = 1'b1;
                end
                nxt.active   = 1'b0;
                rsp.done_res = 1'b1;
            end
            else
            begin
                if (byte_start)
                begin
                    nxt.tx_shift = (cur.byte_count < cfg.write_length) ? cmd.tx_byte : 8'd0;
                    nxt.rx_shift = 8'd0;
                end
                if (!cur.half_phase)
                begin
                    if (cfg.use_mosi)
                    begin
                        nxt.data_level = nxt.tx_shift[pos];
                    end
                    nxt.clock_level = !cpol;
                    sample          = !cpha;
                end
                else
                begin
                    nxt.clock_level = cpol;
                    sample          = cpha;
                end
                if (sample && cfg.use_miso)
                begin
                    nxt.rx_shift[pos] = cmd.miso_level;
                end
                if (cur.half_phase)
                begin
                    if (cur.bit_count >= spim_pkg::LAST_BIT)
                    begin
                        nxt.bit_count = 3'd0;
                        if (cur.byte_count < cfg.read_length)
                        begin
                            rsp.rx_valid = 1'b1;
                            rsp.rx_byte  = nxt.rx_shift;
                            rsp.rx_last  = ({1'b0, cur.byte_count} + 9'd1)
                                           == {1'b0, cfg.read_length};
                        end
                        nxt.byte_count = cur.byte_count + 8'd1;
                    end
                    else
                    begin
                        nxt.bit_count = cur.bit_count + 3'd1;
                    end
                end
                nxt.half_phase = !cur.half_phase;
            end
        end

        rsp.sclk        = nxt.clock_level;
        rsp.mosi        = nxt.data_level;
        rsp.mosi_enable = nxt.active && cfg.use_mosi;
        rsp.select_n    = nxt.select_level;
        rsp.busy_res    = nxt.active;
    end

endmodule

### rtl/spi_master_four_mode.sv
// channel | direction | payload       | transfer when
// cmd     | in        | spim_pkg::cmd_t | cmd_valid && !cmd_stall
// rsp     | out       | spim_pkg::rsp_t | rsp_valid && !rsp_stall
// cfg     | in        | cfg_index/data  | cfg_write
//
// every command gives one response, registered in the output buffer
// one command per cycle while cmd_stall is low; the bus state update is a single pass between registers
// a two-entry output buffer lets a command in while one response waits
// cmd_stall rises only when both output entries are full
// reset: select high, clock and data low, idle; modes 0, msb first, all lines used
module spi_master_four_mode (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  spim_pkg::cmd_t                      cmd_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output spim_pkg::rsp_t                      rsp_data,
    input  logic                                cfg_write,
    input  logic [spim_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [spim_pkg::CFG_DATA_W-1:0]     cfg_data
);

    spim_pkg::cfg_t       cfg_reg;
    spim_pkg::bus_state_t state_reg;
    spim_pkg::bus_state_t state_next;
    spim_pkg::rsp_t       step_rsp;

    spim_pkg::rsp_t       main_reg;
    spim_pkg::rsp_t       main_next;
    logic                 main_valid_reg;
    logic                 main_valid_next;
    spim_pkg::rsp_t       skid_reg;
    spim_pkg::rsp_t       skid_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;

    logic accept;
    logic take;

    assign cmd_stall = skid_valid_reg;
    assign accept    = cmd_valid && !skid_valid_reg;
    assign take      = main_valid_reg && !rsp_stall;
    assign rsp_valid = main_valid_reg;
    assign rsp_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{spi_mode: 2'd0, lsb_first: 1'b0, read_length: 8'd0,
                         write_length: 8'd0, use_mosi: 1'b1, use_miso: 1'b1,
                         use_select: 1'b1};
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                spim_pkg::REG_SPI_MODE:     cfg_reg.spi_mode     <= cfg_data[1:0];
                spim_pkg::REG_LSB_FIRST:    cfg_reg.lsb_first    <= cfg_data[0];
                spim_pkg::REG_READ_LENGTH:  cfg_reg.read_length  <= cfg_data[7:0];
                spim_pkg::REG_WRITE_LENGTH: cfg_reg.write_length <= cfg_data[7:0];
                spim_pkg::REG_USE_MOSI:     cfg_reg.use_mosi     <= cfg_data[0];
                spim_pkg::REG_USE_MISO:     cfg_reg.use_miso     <= cfg_data[0];
                spim_pkg::REG_USE_SELECT:   cfg_reg.use_select   <= cfg_data[0];
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    spim_step u_step (
        .cfg (cfg_reg),
        .cur (state_reg),
        .cmd (cmd_data),
        .nxt (state_next),
        .rsp (step_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{active: 1'b0, byte_count: 8'd0, bit_count: 3'd0,
                           half_phase: 1'b0, tx_shift: 8'd0, rx_shift: 8'd0,
                           clock_level: 1'b0, data_level: 1'b0, select_level: 1'b1};
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // output buffer: main entry drives the port, skid catches one extra response
    always_comb
    begin
        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (!main_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = step_rsp;
                main_valid_next = accept;
            end
        end
        else if (accept)
        begin
            skid_next       = step_rsp;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

### rtl/spim_checker.sv
module spim_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cmd_valid,
    input logic                             cmd_stall,
    input logic                             rsp_valid,
    input logic                             rsp_stall,
    input spim_pkg::rsp_t                   rsp_data
);

    // last byte flag only comes with a received byte
    a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.rx_last |-> rsp_data.rx_valid)
        else $error("rx_last without rx_valid");

    // the closing tick ends the transaction
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res && !rsp_data.rx_valid)
        else $error("done while still busy");

    // a received byte or a driven mosi belongs to a running transaction
    a_rx_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.rx_valid || rsp_data.mosi_enable) |-> rsp_data.busy_res)
        else $error("receive or drive outside a transaction");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed");

    // input is held back only while a response is waiting
    a_stall_needs_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |-> rsp_valid)
        else $error("command stalled with no response pending");

endmodule

bind spi_master_four_mode spim_checker u_spim_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

### tb/sv/tb_spi_master_four_mode.sv
`timescale 1ns / 100ps

module tb_spi_master_four_mode;

    localparam int IDLE_LIMIT  = 5000;
    localparam int ITEM_TARGET = 600;
    localparam logic [spim_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic                             clk;
    logic                             rst_n;
    logic                             cmd_valid;
    logic                             cmd_stall;
    spim_pkg::cmd_t                   cmd_data;
    logic                             rsp_valid;
    logic                             rsp_stall;
    spim_pkg::rsp_t                   rsp_data;
    logic                             cfg_write;
    logic [spim_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [spim_pkg::CFG_DATA_W-1:0]  cfg_data;

    // shadow copy of the registers and of the bus engine
    spim_pkg::cfg_t       regs_m;
    spim_pkg::bus_state_t bus_m;
    spim_pkg::rsp_t       pending_rsp[$];

    int mismatches  = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit quiet       = 1'b0;

    spi_master_four_mode u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 8'($urandom_range(0, 3));
        if (r < 97)
            return 8'($urandom_range(4, 12));
        return 8'($urandom_range(13, 40));
    endfunction

    // 1-bit registers get junk in the upper bits
    function automatic logic [7:0] pick_flag();
        return {7'($urandom), $urandom_range(0, 3) != 0};
    endfunction

    function automatic void reset_model();
        regs_m              = '0;
        regs_m.use_mosi     = 1'b1;
        regs_m.use_miso     = 1'b1;
        regs_m.use_select   = 1'b1;
        bus_m               = '0;
        bus_m.select_level  = 1'b1;
    endfunction

    function automatic void apply_reg(logic [spim_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] d);
        case (idx)
            spim_pkg::REG_SPI_MODE:     regs_m.spi_mode     = d[1:0];
            spim_pkg::REG_LSB_FIRST:    regs_m.lsb_first    = d[0];
            spim_pkg::REG_READ_LENGTH:  regs_m.read_length  = d;
            spim_pkg::REG_WRITE_LENGTH: regs_m.write_length = d;
            spim_pkg::REG_USE_MOSI:     regs_m.use_mosi     = d[0];
            spim_pkg::REG_USE_MISO:     regs_m.use_miso     = d[0];
            spim_pkg::REG_USE_SELECT:   regs_m.use_select   = d[0];
            default: ;
        endcase
    endfunction

    function automatic spim_pkg::rsp_t step_bus(spim_pkg::cmd_t c);
        spim_pkg::rsp_t r;
        logic           cpol;
        logic           cpha;
        logic           take;
        logic [7:0]     total;
        logic [2:0]     pos;
        r     = '0;
        cpol  = regs_m.spi_mode[1];
        cpha  = regs_m.spi_mode[0];
        total = (regs_m.read_length > regs_m.write_length) ?
                regs_m.read_length : regs_m.write_length;
        r.byte_position = bus_m.byte_count;
        if (c.command == spim_pkg::CMD_START)
        begin
            bus_m.active      = 1'b1;
            bus_m.byte_count  = '0;
            bus_m.bit_count   = '0;
            bus_m.half_phase  = 1'b0;
            bus_m.rx_shift    = '0;
            bus_m.tx_shift    = '0;
            bus_m.clock_level = cpol;
            if (regs_m.use_select)
                bus_m.select_level = 1'b0;
            r.byte_position = '0;
        end
        else if (bus_m.active)
        begin
            if (!bus_m.half_phase && bus_m.bit_count == 0 && bus_m.byte_count >= total)
            begin
                if (regs_m.use_select)
                    bus_m.select_level = 1'b1;
                bus_m.active = 1'b0;
                r.done_res   = 1'b1;
            end
            else
            begin
                if (!bus_m.half_phase && bus_m.bit_count == 0)
                begin
                    bus_m.tx_shift = (bus_m.byte_count < regs_m.write_length) ?
                                     c.tx_byte : 8'h00;
                    bus_m.rx_shift = '0;
                end
                pos = regs_m.lsb_first ? bus_m.bit_count
                                       : spim_pkg::LAST_BIT - bus_m.bit_count;
                if (!bus_m.half_phase)
                begin
                    if (regs_m.use_mosi)
                        bus_m.data_level = bus_m.tx_shift[pos];
                    bus_m.clock_level = ~cpol;
                    take = ~cpha;
                end
                else
                begin
                    bus_m.clock_level = cpol;
                    take = cpha;
                end
                if (take && regs_m.use_miso)
                    bus_m.rx_shift[pos] = c.miso_level;
                if (bus_m.half_phase)
                begin
                    if (bus_m.bit_count == spim_pkg::LAST_BIT)
                    begin
                        bus_m.bit_count = '0;
                        if (bus_m.byte_count < regs_m.read_length)
                        begin
                            r.rx_valid = 1'b1;
                            r.rx_byte  = bus_m.rx_shift;
                            r.rx_last  = (9'(bus_m.byte_count) + 9'd1 ==
                                          9'(regs_m.read_length));
                        end
                        bus_m.byte_count = bus_m.byte_count + 8'd1;
                    end
                    else
                        bus_m.bit_count = bus_m.bit_count + 3'd1;
                end
                bus_m.half_phase = ~bus_m.half_phase;
            end
        end
        r.sclk        = bus_m.clock_level;
        r.mosi        = bus_m.data_level;
        r.mosi_enable = bus_m.active && regs_m.use_mosi;
        r.select_n    = bus_m.select_level;
        r.busy_res    = bus_m.active;
        return r;
    endfunction

    task automatic send_cmd(logic command, logic miso, logic [7:0] txb);
        spim_pkg::cmd_t c;
        int             gap;
        c.command    = command;
        c.miso_level = miso;
        c.tx_byte    = txb;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        // ticks while idle do nothing, so they are not counted
        if (command == spim_pkg::CMD_START || bus_m.active)
            items_sent++;
        pending_rsp.push_back(step_bus(c));
    endtask

    task automatic send_tick();
        send_cmd(spim_pkg::CMD_TICK, 1'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(logic [spim_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] d);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        apply_reg(idx, d);
    endtask

    task automatic program_regs(input logic [7:0] mode, lsb, rlen, wlen, umosi, umiso, usel);
        drain();
        write_reg(spim_pkg::REG_SPI_MODE, mode);
        write_reg(spim_pkg::REG_LSB_FIRST, lsb);
        write_reg(spim_pkg::REG_READ_LENGTH, rlen);
        write_reg(spim_pkg::REG_WRITE_LENGTH, wlen);
        write_reg(spim_pkg::REG_USE_MOSI, umosi);
        write_reg(spim_pkg::REG_USE_MISO, umiso);
        write_reg(spim_pkg::REG_USE_SELECT, usel);
        write_reg(REG_UNUSED, 8'($urandom));
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic program_random();
        program_regs(8'($urandom), {7'($urandom), 1'($urandom)}, pick_len(), pick_len(),
                     pick_flag(), pick_flag(), pick_flag());
    endtask

    // start, ticks until the shadow engine is idle; may restart/reprogram
    task automatic run_transfer(bit allow_restart, bit allow_reconfig);
        int restart_at;
        int reconfig_at;
        int n;
        restart_at  = (allow_restart && $urandom_range(0, 9) == 0) ?
                      $urandom_range(0, 40) : -1;
        reconfig_at = (allow_reconfig && $urandom_range(0, 7) == 0) ?
                      $urandom_range(1, 40) : -1;
        send_cmd(spim_pkg::CMD_START, 1'($urandom), 8'($urandom));
        n = 0;
        while (bus_m.active)
        begin
            if (n == reconfig_at)
                program_random();
            if (n == restart_at)
                send_cmd(spim_pkg::CMD_START, 1'($urandom), 8'($urandom));
            else
                send_tick();
            n++;
        end
    endtask

    task automatic test_basics();
        // ticks while idle, then a transaction with both lengths zero
        send_cmd(spim_pkg::CMD_TICK, 1'b1, 8'hFF);
        send_cmd(spim_pkg::CMD_TICK, 1'b0, 8'h00);
        send_cmd(spim_pkg::CMD_START, 1'b1, 8'hFF);
        send_cmd(spim_pkg::CMD_TICK, 1'b1, 8'hFF);
        // one byte each way, restarted after a few half bits
        program_regs(8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        send_cmd(spim_pkg::CMD_START, 1'b0, 8'h00);
        repeat (3) send_cmd(spim_pkg::CMD_TICK, 1'b1, 8'hFF);
        send_cmd(spim_pkg::CMD_START, 1'b0, 8'h00);
        while (bus_m.active) send_cmd(spim_pkg::CMD_TICK, 1'b1, 8'hFF);
    endtask

    task automatic test_mode_sweep();
        for (int m = 0; m < 4; m++)
        begin
            for (int lsb = 0; lsb < 2; lsb++)
            begin
                program_regs(8'(m), 8'(lsb), 8'd1, 8'(1 + lsb),
                             8'(m != 1), 8'(m != 2), 8'(m != 3));
                run_transfer(1'b0, 1'b0);
            end
        end
    endtask

    task automatic test_long_transfer();
        quiet = 1'b1;
        program_regs(8'd3, 8'd1, 8'd20, 8'd3, 8'd1, 8'd1, 8'd1);
        run_transfer(1'b0, 1'b0);
        quiet = 1'b0;
        program_regs(8'd0, 8'd0, 8'd2, 8'd16, 8'd1, 8'd0, 8'd0);
        run_transfer(1'b0, 1'b0);
    endtask

    task automatic test_reconfig_midway();
        program_regs(8'd1, 8'd0, 8'd3, 8'd3, 8'd1, 8'd1, 8'd1);
        send_cmd(spim_pkg::CMD_START, 1'b0, 8'h5A);
        repeat (20) send_tick();
        program_regs(8'd2, 8'd1, 8'd3, 8'd3, 8'd0, 8'd1, 8'd0);
        repeat (20) send_tick();
        // shorter lengths close the transaction at the next byte boundary
        program_regs(8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        while (bus_m.active) send_tick();
    endtask

    task automatic test_random();
        int first;
        first = items_sent;
        while (items_sent - first < ITEM_TARGET)
        begin
            quiet = ($urandom_range(0, 7) == 0);
            program_random();
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) send_tick();
                run_transfer(1'b1, 1'b1);
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        spim_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response with nothing pending: %h", rsp_data);
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("sclk", 8'(want.sclk), 8'(rsp_data.sclk));
                check_field("mosi", 8'(want.mosi), 8'(rsp_data.mosi));
                check_field("mosi_enable", 8'(want.mosi_enable),
                            8'(rsp_data.mosi_enable));
                check_field("select_n", 8'(want.select_n), 8'(rsp_data.select_n));
                check_field("rx_byte", want.rx_byte, rsp_data.rx_byte);
                check_field("rx_valid", 8'(want.rx_valid), 8'(rsp_data.rx_valid));
                check_field("rx_last", 8'(want.rx_last), 8'(rsp_data.rx_last));
                check_field("byte_position", want.byte_position, rsp_data.byte_position);
                check_field("done_res", 8'(want.done_res), 8'(rsp_data.done_res));
                check_field("busy_res", 8'(want.busy_res), 8'(rsp_data.busy_res));
            end
        end
    end

    // any cycle with a transfer on either channel resets the count
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_data  = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reset_model();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basics();
        test_mode_sweep();
        test_reconfig_midway();
        test_long_transfer();
        test_random();

        drain();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### spi_master_four_mode.f
rtl/spim_pkg.sv
rtl/spim_step.sv
rtl/spi_master_four_mode.sv
rtl/spim_checker.sv
tb/sv/tb_spi_master_four_mode.sv
